### sv/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared constants for the polyline rectangle clipper: register indexes,
// sequencer state codes, next-item and border codes and datapath widths.
// ----------------------------------------------------------------------------
package prc_pkg;

   localparam int unsigned CoordW = 31;
   localparam int unsigned CsrIdxW = 2;

   typedef logic [CoordW-1:0] coord_type;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_LEFT   = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_RIGHT  = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_TOP    = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_BOTTOM = 2'd3;

   // sequencer states
   localparam int unsigned StW = 3;
   localparam logic [StW-1:0] ST_IDLE  = 3'd0;
   localparam logic [StW-1:0] ST_CHECK = 3'd1;
   localparam logic [StW-1:0] ST_MUL   = 3'd2;
   localparam logic [StW-1:0] ST_DINIT = 3'd3;
   localparam logic [StW-1:0] ST_DIV   = 3'd4;
   localparam logic [StW-1:0] ST_FIX   = 3'd5;
   localparam logic [StW-1:0] ST_POST  = 3'd6;
   localparam logic [StW-1:0] ST_WAIT  = 3'd7;

   // what follows an emitted item
   localparam logic [1:0] NXT_DONE   = 2'd0;
   localparam logic [1:0] NXT_POINT  = 2'd1;
   localparam logic [1:0] NXT_SEARCH = 2'd2;

   // border of a crossing candidate
   localparam logic [1:0] BRD_TOP    = 2'd0;
   localparam logic [1:0] BRD_BOTTOM = 2'd1;
   localparam logic [1:0] BRD_LEFT   = 2'd2;
   localparam logic [1:0] BRD_RIGHT  = 2'd3;

endpackage

### sv/polyline_rect_clipper.sv
// ----------------------------------------------------------------------------
// polyline_rect_clipper
// Clips a stream of polyline points against a tile rectangle (y downward).
// ----------------------------------------------------------------------------
// Each accepted point gives zero, one or two clipped points. A point that stays
// inside the rectangle passes straight through: its result item is valid on
// the cycle after it is accepted. A point whose segment crosses the border
// runs an ordered search over eight border candidates (entering top, bottom,
// left, right, then leaving). A candidate that does not apply takes only the
// check step. One that applies runs the check, a signed multiply, a divider
// setup, the shared radix-2 divider and a range check. Entering and leaving
// the same border exclude each other, so at most four candidates apply in one
// search. A point needs up to two searches, and each result item waits for
// its output handshake.
// req_stall is high while a point is in work. The user must write the
// rectangle through csr_* only while the block is idle; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module polyline_rect_clipper (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  prc_pkg::coord_type       req_point_x,
   input  prc_pkg::coord_type       req_point_y,
   input  logic                     req_first_point,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output prc_pkg::coord_type       rsp_out_x,
   output prc_pkg::coord_type       rsp_out_y,
   output logic                     rsp_starts_piece,
   output logic                     rsp_ends_piece,
   output logic                     rsp_last,
   input  logic                     csr_write,
   input  logic [prc_pkg::CsrIdxW-1:0] csr_index,
   input  prc_pkg::coord_type       csr_wdata
);
   import prc_pkg::*;

   // rectangle
   coord_type left_ff, right_ff, top_ff, bottom_ff;

   // sequencer
   logic [StW-1:0] state_ff, state_in;
   logic [2:0]     cand_ff, cand_in;
   logic           phase_ff, phase_in;
   logic [1:0]     nxt_ff, nxt_in;
   logic [4:0]     cnt_ff, cnt_in;

   // point state
   coord_type x_ff, x_in, y_ff, y_in;
   coord_type prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic      prev_in_ff, prev_in_in;   // previous point was inside
   logic      was_in_ff, was_in_in;     // same, latched for the current item
   logic      ins_ff, ins_in;           // current point inside
   logic      pend_ff, pend_in;         // next emitted point starts a piece

   // search
   coord_type sx_ff, sx_in, sy_ff, sy_in;
   coord_type bx_ff, bx_in, by_ff, by_in;
   logic      found_ff, found_in;

   // shared multiply / divide unit
   logic signed [31:0] ma_ff, ma_in, mb_ff, mb_in;
   logic               dneg_ff, dneg_in;
   logic [31:0]        dmag_ff, dmag_in;
   coord_type          base_ff, base_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [32:0]        rem_ff, rem_in;
   logic [31:0]        qs_ff, qs_in;
   logic               qneg_ff, qneg_in;

   // result register
   logic      rv_ff, rv_in;
   coord_type ox_ff, ox_in, oy_ff, oy_in;
   logic      os_ff, os_in, oe_ff, oe_in, ol_ff, ol_in;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         right_ff  <= '1;
         top_ff    <= '0;
         bottom_ff <= '1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LEFT:   left_ff   <= csr_wdata;
            CSR_RIGHT:  right_ff  <= csr_wdata;
            CSR_TOP:    top_ff    <= csr_wdata;
            CSR_BOTTOM: bottom_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rv_ff;
   assign rsp_out_x        = ox_ff;
   assign rsp_out_y        = oy_ff;
   assign rsp_starts_piece = os_ff;
   assign rsp_ends_piece   = oe_ff;
   assign rsp_last         = ol_ff;

   // signed difference of two coordinates
   function automatic logic signed [31:0] sdiff(input coord_type a, input coord_type b);
      sdiff = $signed({1'b0, a}) - $signed({1'b0, b});
   endfunction

   logic               req_ins;
   logic [1:0]         brd;
   logic               ent;
   logic               cond;
   logic signed [31:0] den;
   logic [62:0]        nmag;
   logic [33:0]        r2;
   logic [33:0]        dsub;
   logic signed [32:0] qsig;
   logic signed [33:0] tval;
   logic               t_ok;
   logic               on_border;
   logic               rsp_take;

   assign req_ins = (req_point_x >= left_ff) && (req_point_x <= right_ff) &&
                    (req_point_y >= top_ff) && (req_point_y <= bottom_ff);
   assign brd  = cand_ff[1:0];
   assign ent  = ~cand_ff[2];
   assign rsp_take = rv_ff && !rsp_stall;
   assign nmag = prod_ff[63] ? 63'(-prod_ff) : prod_ff[62:0];
   assign r2   = {rem_ff, qs_ff[31]};
   assign dsub = r2 - {2'b00, dmag_ff};
   assign qsig = qneg_ff ? -$signed({1'b0, qs_ff}) : $signed({1'b0, qs_ff});
   assign tval = $signed({3'b000, base_ff}) + 34'(qsig);
   assign on_border = (sx_ff == right_ff) || (sx_ff == left_ff) ||
                      (sy_ff == top_ff) || (sy_ff == bottom_ff);

   always_comb begin
      unique case (brd)
         BRD_TOP:    cond = ent ? (sy_ff < top_ff && y_ff >= top_ff)
                                : (sy_ff > top_ff && y_ff <= top_ff);
         BRD_BOTTOM: cond = ent ? (sy_ff > bottom_ff && y_ff <= bottom_ff)
                                : (sy_ff < bottom_ff && y_ff >= bottom_ff);
         BRD_LEFT:   cond = ent ? (sx_ff < left_ff && x_ff >= left_ff)
                                : (sx_ff > left_ff && x_ff <= left_ff);
         default:    cond = ent ? (sx_ff > right_ff && x_ff <= right_ff)
                                : (sx_ff < right_ff && x_ff >= right_ff);
      endcase
      if (brd == BRD_TOP || brd == BRD_BOTTOM) begin
         t_ok = (tval >= $signed({3'b000, left_ff})) && (tval <= $signed({3'b000, right_ff}));
      end else begin
         t_ok = (tval >= $signed({3'b000, top_ff})) && (tval <= $signed({3'b000, bottom_ff}));
      end
   end

   always_comb begin
      state_in = state_ff;  cand_in = cand_ff;  phase_in = phase_ff;
      nxt_in = nxt_ff;      cnt_in = cnt_ff;
      x_in = x_ff;          y_in = y_ff;
      prev_x_in = prev_x_ff; prev_y_in = prev_y_ff; prev_in_in = prev_in_ff;
      was_in_in = was_in_ff; ins_in = ins_ff;     pend_in = pend_ff;
      sx_in = sx_ff;        sy_in = sy_ff;        bx_in = bx_ff;  by_in = by_ff;
      found_in = found_ff;
      ma_in = ma_ff;        mb_in = mb_ff;        dneg_in = dneg_ff;
      dmag_in = dmag_ff;    base_in = base_ff;    prod_in = prod_ff;
      rem_in = rem_ff;      qs_in = qs_ff;        qneg_in = qneg_ff;
      rv_in = rv_ff;        ox_in = ox_ff;        oy_in = oy_ff;
      os_in = os_ff;        oe_in = oe_ff;        ol_in = ol_ff;
      den = '0;

      if (rsp_take) rv_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in = req_point_x;
               y_in = req_point_y;
               ins_in = req_ins;
               was_in_in = prev_in_ff;
               sx_in = prev_x_ff;
               sy_in = prev_y_ff;
               bx_in = req_point_x;
               by_in = req_point_y;
               prev_x_in = req_point_x;
               prev_y_in = req_point_y;
               prev_in_in = req_ins;
               cand_in = '0;
               phase_in = 1'b0;
               found_in = 1'b0;
               if (req_first_point || (prev_in_ff && req_ins)) begin
                  // plain pass of the point itself
                  if (req_ins) begin
                     rv_in = 1'b1;
                     ox_in = req_point_x;  oy_in = req_point_y;
                     os_in = req_first_point | pend_ff;
                     oe_in = 1'b0;  ol_in = 1'b1;
                     pend_in = 1'b0;
                     nxt_in = NXT_DONE;
                     state_in = ST_WAIT;
                  end else begin
                     pend_in = 1'b1;
                  end
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end

         ST_CHECK: begin
            if (cond) begin
               unique case (brd)
                  BRD_TOP: begin
                     base_in = sx_ff; ma_in = sdiff(x_ff, sx_ff);
                     mb_in = sdiff(top_ff, sy_ff); den = sdiff(y_ff, sy_ff);
                  end
                  BRD_BOTTOM: begin
                     base_in = sx_ff; ma_in = sdiff(x_ff, sx_ff);
                     mb_in = sdiff(sy_ff, bottom_ff); den = sdiff(sy_ff, y_ff);
                  end
                  BRD_LEFT: begin
                     base_in = sy_ff; ma_in = sdiff(y_ff, sy_ff);
                     mb_in = sdiff(left_ff, sx_ff); den = sdiff(x_ff, sx_ff);
                  end
                  default: begin
                     base_in = sy_ff; ma_in = sdiff(y_ff, sy_ff);
                     mb_in = sdiff(sx_ff, right_ff); den = sdiff(sx_ff, x_ff);
                  end
               endcase
               dneg_in = den[31];
               dmag_in = den[31] ? 32'(-den) : den;
               state_in = ST_MUL;
            end else if (cand_ff == 3'd7) begin
               // no crossing: fall back to the start point if on a border line
               if (on_border) begin
                  bx_in = sx_ff;  by_in = sy_ff;
               end
               found_in = 1'b0;
               state_in = ST_POST;
            end else begin
               cand_in = cand_ff + 3'd1;
            end
         end

         ST_MUL: begin
            prod_in = ma_ff * mb_ff;
            state_in = ST_DINIT;
         end

         ST_DINIT: begin
            // quotient is known to fit 32 bits, so the top bits start as remainder
            rem_in = {2'b00, nmag[62:32]};
            qs_in = nmag[31:0];
            qneg_in = prod_ff[63] ^ dneg_ff;
            cnt_in = '0;
            state_in = ST_DIV;
         end

         ST_DIV: begin
            if (!dsub[33]) begin
               rem_in = dsub[32:0];
               qs_in = {qs_ff[30:0], 1'b1};
            end else begin
               rem_in = r2[32:0];
               qs_in = {qs_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) state_in = ST_FIX;
         end

         ST_FIX: begin
            if (t_ok) begin
               if (brd == BRD_TOP) begin
                  bx_in = tval[30:0]; by_in = top_ff;
               end else if (brd == BRD_BOTTOM) begin
                  bx_in = tval[30:0]; by_in = bottom_ff;
               end else if (brd == BRD_LEFT) begin
                  bx_in = left_ff;    by_in = tval[30:0];
               end else begin
                  bx_in = right_ff;   by_in = tval[30:0];
               end
               found_in = 1'b1;
               state_in = ST_POST;
            end else if (cand_ff == 3'd7) begin
               if (on_border) begin
                  bx_in = sx_ff;  by_in = sy_ff;
               end
               found_in = 1'b0;
               state_in = ST_POST;
            end else begin
               cand_in = cand_ff + 3'd1;
               state_in = ST_CHECK;
            end
         end

         ST_POST: begin
            state_in = ST_WAIT;
            rv_in = 1'b1;
            os_in = pend_ff;
            ox_in = bx_ff;  oy_in = by_ff;
            oe_in = 1'b0;   ol_in = 1'b0;
            pend_in = 1'b0;
            nxt_in = NXT_DONE;
            if (phase_ff) begin
               oe_in = 1'b1;  ol_in = 1'b1;  pend_in = 1'b1;
            end else if (was_in_ff) begin
               // leaving the tile
               if (!found_ff) begin
                  ox_in = sx_ff;  oy_in = sy_ff;
               end
               oe_in = 1'b1;  ol_in = 1'b1;  pend_in = 1'b1;
            end else if (ins_ff) begin
               nxt_in = NXT_POINT;
            end else if (found_ff) begin
               nxt_in = NXT_SEARCH;
            end else begin
               rv_in = 1'b0;
               os_in = os_ff;
               pend_in = pend_ff;
               state_in = ST_IDLE;
            end
         end

         default: begin // ST_WAIT
            if (rsp_take) begin
               unique case (nxt_ff)
                  NXT_POINT: begin
                     rv_in = 1'b1;
                     ox_in = x_ff;  oy_in = y_ff;
                     os_in = pend_ff;
                     oe_in = 1'b0;  ol_in = 1'b1;
                     pend_in = 1'b0;
                     nxt_in = NXT_DONE;
                  end
                  NXT_SEARCH: begin
                     sx_in = bx_ff;  sy_in = by_ff;
                     cand_in = '0;
                     phase_in = 1'b1;
                     state_in = ST_CHECK;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rv_ff      <= 1'b0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         prev_in_ff <= 1'b0;
         pend_ff    <= 1'b1;
         cand_ff    <= '0;
         phase_ff   <= 1'b0;
         nxt_ff     <= NXT_DONE;
         cnt_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         rv_ff      <= rv_in;
         prev_x_ff  <= prev_x_in;
         prev_y_ff  <= prev_y_in;
         prev_in_ff <= prev_in_in;
         pend_ff    <= pend_in;
         cand_ff    <= cand_in;
         phase_ff   <= phase_in;
         nxt_ff     <= nxt_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;        y_ff <= y_in;
      was_in_ff <= was_in_in; ins_ff <= ins_in;
      sx_ff <= sx_in;      sy_ff <= sy_in;
      bx_ff <= bx_in;      by_ff <= by_in;
      found_ff <= found_in;
      ma_ff <= ma_in;      mb_ff <= mb_in;
      dneg_ff <= dneg_in;  dmag_ff <= dmag_in;
      base_ff <= base_in;  prod_ff <= prod_in;
      rem_ff <= rem_in;    qs_ff <= qs_in;    qneg_ff <= qneg_in;
      ox_ff <= ox_in;      oy_ff <= oy_in;
      os_ff <= os_in;      oe_ff <= oe_in;    ol_ff <= ol_in;
   end

endmodule
